### hdl/s2hkr_pkg.sv
// ----------------------------------------------------------------------------
// Serial to keyboard report package
// Shared op codes, controller states and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package s2hkr_pkg;

   // Item operation codes.
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_POLL = 2'd2;

   // Frame parser phases.
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SCAN   = 2'd1;
   localparam logic [1:0] PH_STATE  = 2'd2;

   localparam logic [7:0] PRESS_MARK = 8'h55;
   localparam int         MOD_FIRST  = 224;
   localparam int         MAX_SLOTS  = 6;
   localparam int         CODE_W     = 7;
   localparam int         REPORT_W   = 8 + MAX_SLOTS * CODE_W;
   localparam logic [9:0] IDLE_RESET = 10'd500;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_poll;
      logic scan_last;
      logic out_free;
   } ctrl_status_type;

endpackage

### hdl/s2hkr_ctrl.sv
// ----------------------------------------------------------------------------
// Serial to keyboard report controller
// Sequences one item: capture, key table scan for polls, then commit.
// ----------------------------------------------------------------------------
module s2hkr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  s2hkr_pkg::ctrl_status_type  status,
   output s2hkr_pkg::ctrl_cmd_type     cmd
);
   import s2hkr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.is_poll) begin
               cmd.step = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_COMMIT;
               end
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // Hold the finished item until the result register can take it.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/s2hkr_dp.sv
// ----------------------------------------------------------------------------
// Serial to keyboard report datapath
// Frame parser, key table, grouped key scan, idle timer and result register.
// ----------------------------------------------------------------------------
module s2hkr_dp #(
   parameter int KEY_SLOTS  = 6,
   parameter int SCAN_LIMIT = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  s2hkr_pkg::ctrl_cmd_type     cmd,
   output s2hkr_pkg::ctrl_status_type  status,
   input  logic [1:0]                  req_op,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_endpoint_ready,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [9:0]                  csr_idle_period_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_report_sent,
   output logic [7:0]                  rsp_modifiers,
   output logic [6:0]                  rsp_key_0,
   output logic [6:0]                  rsp_key_1,
   output logic [6:0]                  rsp_key_2,
   output logic [6:0]                  rsp_key_3,
   output logic [6:0]                  rsp_key_4,
   output logic [6:0]                  rsp_key_5
);
   import s2hkr_pkg::*;

   localparam int GROUPS = (SCAN_LIMIT + 7) / 8;
   localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   // Captured item.
   logic [1:0]              op_ff, op_in;
   logic [7:0]              data_ff, data_in;
   logic                    ready_ff, ready_in;

   // Persistent block state.
   logic [1:0]              phase_ff, phase_in;
   logic [7:0]              pend_ff, pend_in;
   logic [255:0]            keys_ff, keys_in;
   logic [9:0]              remain_ff, remain_in;
   logic [REPORT_W-1:0]     last_ff, last_in;
   logic [9:0]              period_ff, period_in;

   // Scan working state.
   logic [GW-1:0]           grp_ff, grp_in;
   logic [2:0]              used_ff, used_in;
   logic [CODE_W-1:0]       slots_ff [MAX_SLOTS];
   logic [CODE_W-1:0]       slots_in [MAX_SLOTS];
   logic [CODE_W-1:0]       slots_scan [MAX_SLOTS];
   logic [2:0]              used_scan;
   logic [7:0]              grp_bits;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_sent_ff, rsp_sent_in;
   logic [7:0]              rsp_mods_ff, rsp_mods_in;
   logic [CODE_W-1:0]       rsp_keys_ff [MAX_SLOTS];
   logic [CODE_W-1:0]       rsp_keys_in [MAX_SLOTS];

   logic [REPORT_W-1:0]     report;
   logic                    send;

   assign grp_bits = keys_ff[{grp_ff, 3'b000} +: 8];

   // One group of eight table entries per step; each pressed key in range
   // takes the next free slot.
   always_comb begin : scan_group
      logic [2:0] rank;
      logic [7:0] idx;
      rank       = used_ff;
      slots_scan = slots_ff;
      for (int j = 0; j < 8; j++) begin
         idx = 8'({grp_ff, 3'(j)});
         if (grp_bits[j] && ({1'b0, idx} < 9'(SCAN_LIMIT)) && (rank < 3'(KEY_SLOTS))) begin
            for (int s = 0; s < MAX_SLOTS; s++) begin
               if (3'(s) == rank) begin
                  slots_scan[s] = idx[CODE_W-1:0];
               end
            end
            rank = rank + 3'd1;
         end
      end
      used_scan = rank;
   end

   assign report = {slots_ff[5], slots_ff[4], slots_ff[3], slots_ff[2], slots_ff[1],
                    slots_ff[0], keys_ff[MOD_FIRST +: 8]};

   always_comb begin
      op_in        = op_ff;
      data_in      = data_ff;
      ready_in     = ready_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      keys_in      = keys_ff;
      remain_in    = remain_ff;
      last_in      = last_ff;
      period_in    = period_ff;
      grp_in       = grp_ff;
      used_in      = used_ff;
      slots_in     = slots_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sent_in  = rsp_sent_ff;
      rsp_mods_in  = rsp_mods_ff;
      rsp_keys_in  = rsp_keys_ff;
      send         = 1'b0;

      if (csr_valid) begin
         period_in = csr_idle_period_ms;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         op_in    = req_op;
         data_in  = req_data_byte;
         ready_in = req_endpoint_ready;
         grp_in   = '0;
         used_in  = 3'd0;
         for (int s = 0; s < MAX_SLOTS; s++) begin
            slots_in[s] = '0;
         end
      end

      if (cmd.step) begin
         grp_in   = grp_ff + GW'(1);
         used_in  = used_scan;
         slots_in = slots_scan;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_sent_in  = 1'b0;
         rsp_mods_in  = '0;
         for (int s = 0; s < MAX_SLOTS; s++) begin
            rsp_keys_in[s] = '0;
         end
         case (op_ff)
            OP_BYTE: begin
               case (phase_ff)
                  PH_SCAN: begin
                     pend_in  = data_ff;
                     phase_in = PH_STATE;
                  end
                  PH_STATE: begin
                     keys_in[pend_ff] = (data_ff == PRESS_MARK);
                     phase_in         = PH_HEADER;
                  end
                  default: begin
                     // A non-zero header byte is dropped.
                     phase_in = (data_ff == 8'd0) ? PH_SCAN : PH_HEADER;
                  end
               endcase
            end
            OP_TICK: begin
               if (remain_ff != 10'd0) begin
                  remain_in = remain_ff - 10'd1;
               end
            end
            OP_POLL: begin
               send = (report != last_ff);
               if ((period_ff != 10'd0) && (remain_ff == 10'd0)) begin
                  remain_in = period_ff;
                  send      = 1'b1;
               end
               if (ready_ff && send) begin
                  last_in     = report;
                  rsp_sent_in = 1'b1;
                  rsp_mods_in = report[7:0];
                  rsp_keys_in = slots_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pend_ff      <= '0;
         keys_ff      <= '0;
         remain_ff    <= '0;
         last_ff      <= '0;
         period_ff    <= IDLE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         keys_ff      <= keys_in;
         remain_ff    <= remain_in;
         last_ff      <= last_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      data_ff     <= data_in;
      ready_ff    <= ready_in;
      grp_ff      <= grp_in;
      used_ff     <= used_in;
      slots_ff    <= slots_in;
      rsp_sent_ff <= rsp_sent_in;
      rsp_mods_ff <= rsp_mods_in;
      rsp_keys_ff <= rsp_keys_in;
   end

   assign status.is_poll   = (op_ff == OP_POLL);
   assign status.scan_last = (grp_ff == GW'(GROUPS - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_report_sent = rsp_sent_ff;
   assign rsp_modifiers   = rsp_mods_ff;
   assign rsp_key_0       = rsp_keys_ff[0];
   assign rsp_key_1       = rsp_keys_ff[1];
   assign rsp_key_2       = rsp_keys_ff[2];
   assign rsp_key_3       = rsp_keys_ff[3];
   assign rsp_key_4       = rsp_keys_ff[4];
   assign rsp_key_5       = rsp_keys_ff[5];

   // The scan never fills more slots than configured.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (used_ff <= 3'(KEY_SLOTS)))
      else $error("key slot count overran");

   // The parser never reaches the unused phase code.
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("frame parser in unused phase");

   // A result that sends no report carries an all-zero report.
   a_unsent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_sent_ff) |-> ((rsp_mods_ff == 8'd0) &&
         (rsp_keys_ff[0] == '0) && (rsp_keys_ff[5] == '0)))
      else $error("unsent result carries report data");

endmodule

### hdl/serial_to_hid_keyboard_report.sv
// ----------------------------------------------------------------------------
// Serial to keyboard report
// Parses three-byte key frames from a serial stream into a key table and
// builds boot keyboard reports on poll, with an idle resend timer.
// ----------------------------------------------------------------------------
// A byte or tick beat is captured and then committed; a poll beat is first
// put through a key table scan of eight entries per cycle. The commit waits
// until the result register is free. One item is in work at a time; the
// next beat is taken once the item in work has been committed, even while
// its result still waits downstream.
// Reset (synchronous, active high) clears the key table at once, with no
// clearing pass, and loads the idle period with 500.
// ----------------------------------------------------------------------------
module serial_to_hid_keyboard_report #(
   parameter int KEY_SLOTS  = 6,
   parameter int SCAN_LIMIT = 128
) (
   input  logic       clock,
   input  logic       reset,
   // Item channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic       req_endpoint_ready,
   // Idle period register write channel.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_idle_period_ms,
   // Result channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_report_sent,
   output logic [7:0] rsp_modifiers,
   output logic [6:0] rsp_key_0,
   output logic [6:0] rsp_key_1,
   output logic [6:0] rsp_key_2,
   output logic [6:0] rsp_key_3,
   output logic [6:0] rsp_key_4,
   output logic [6:0] rsp_key_5
);
   import s2hkr_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // The controller walks each accepted beat through capture, an optional
   // scan of the key table for polls, and a commit into the result register.
   s2hkr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the parser, key table, idle timer, last report sent
   // and the result register that decouples the two channels.
   s2hkr_dp #(
      .KEY_SLOTS  (KEY_SLOTS),
      .SCAN_LIMIT (SCAN_LIMIT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_endpoint_ready (req_endpoint_ready),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_idle_period_ms (csr_idle_period_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_report_sent    (rsp_report_sent),
      .rsp_modifiers      (rsp_modifiers),
      .rsp_key_0          (rsp_key_0),
      .rsp_key_1          (rsp_key_1),
      .rsp_key_2          (rsp_key_2),
      .rsp_key_3          (rsp_key_3),
      .rsp_key_4          (rsp_key_4),
      .rsp_key_5          (rsp_key_5)
   );

endmodule

### dv/serial_to_hid_keyboard_report_test.sv
// ----------------------------------------------------------------------------
// Serial to keyboard report testbench
// Drives serial bytes, millisecond ticks and report polls into the block,
// predicts every result beat from a behavioral copy of the key table, frame
// parser and idle timer, and checks each beat field by field. Both channels
// idle at random, and the idle period register is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_to_hid_keyboard_report_test;
   import s2hkr_pkg::*;

   // The block is built with its default sizes.
   localparam int KEY_SLOTS   = 6;
   localparam int SCAN_LIMIT  = 128;
   // The one op code that the package leaves unnamed; the block ignores it.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 275;

   // One result beat as the block presents it.
   typedef struct packed {
      logic                               sent;
      logic [7:0]                         mods;
      logic [MAX_SLOTS-1:0][CODE_W-1:0]   keys;
   } kbd_report_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = OP_BYTE;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_endpoint_ready = 1'b0;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [9:0] csr_idle_period_ms = 10'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_report_sent;
   logic [7:0] rsp_modifiers;
   logic [6:0] rsp_key_0;
   logic [6:0] rsp_key_1;
   logic [6:0] rsp_key_2;
   logic [6:0] rsp_key_3;
   logic [6:0] rsp_key_4;
   logic [6:0] rsp_key_5;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int idle_pct  = 29;
   int stall_pct = 29;
   int error_count = 0;
   int quiet_cycles = 0;

   // Reports predicted for accepted items, oldest first.
   kbd_report_type pending_reports[$];

   // Behavioral state of the block: the key table, the frame parser, the idle
   // timer and the last report that actually went out to the host.
   logic [255:0]        key_down = '0;
   logic [1:0]          parse_phase = PH_HEADER;
   logic [7:0]          held_scancode = 8'h00;
   logic [9:0]          idle_left = 10'd0;
   logic [9:0]          idle_period = IDLE_RESET;
   logic [REPORT_W-1:0] sent_report = '0;

   serial_to_hid_keyboard_report #(
      .KEY_SLOTS  (KEY_SLOTS),
      .SCAN_LIMIT (SCAN_LIMIT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_endpoint_ready (req_endpoint_ready),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_idle_period_ms (csr_idle_period_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_report_sent    (rsp_report_sent),
      .rsp_modifiers      (rsp_modifiers),
      .rsp_key_0          (rsp_key_0),
      .rsp_key_1          (rsp_key_1),
      .rsp_key_2          (rsp_key_2),
      .rsp_key_3          (rsp_key_3),
      .rsp_key_4          (rsp_key_4),
      .rsp_key_5          (rsp_key_5)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Works out the result beat of one item and advances the behavioral state.
   // Anything other than a poll answers with an all-zero beat.
   function automatic kbd_report_type predict_report(input logic [1:0] op,
                                                     input logic [7:0] data,
                                                     input logic ep_ready);
      kbd_report_type      beat;
      logic [REPORT_W-1:0] fresh;
      logic                send;
      int                  used;
      beat = '0;
      case (op)
         OP_BYTE: begin
            // A frame is a zero header, the scancode, then the state byte.
            // Any other byte in the header position is simply dropped.
            if (parse_phase == PH_SCAN) begin
               held_scancode = data;
               parse_phase = PH_STATE;
            end else if (parse_phase == PH_STATE) begin
               key_down[held_scancode] = (data == PRESS_MARK);
               parse_phase = PH_HEADER;
            end else begin
               parse_phase = (data == 8'h00) ? PH_SCAN : PH_HEADER;
            end
         end
         OP_TICK: begin
            if (idle_left != 10'd0)
               idle_left = idle_left - 10'd1;
         end
         OP_POLL: begin
            // Modifiers come from the eight keys at codes 224 to 231; the
            // key slots take the lowest pressed codes below the scan limit.
            fresh = '0;
            fresh[7:0] = key_down[MOD_FIRST +: 8];
            used = 0;
            for (int k = 0; k < SCAN_LIMIT; k++) begin
               if (used < KEY_SLOTS && key_down[k]) begin
                  fresh[8 + CODE_W * used +: CODE_W] = k[CODE_W-1:0];
                  used++;
               end
            end
            send = (fresh != sent_report);
            // An expired timer forces a resend and reloads, even when the
            // endpoint turns the report away.
            if (idle_period != 10'd0 && idle_left == 10'd0) begin
               idle_left = idle_period;
               send = 1'b1;
            end
            if (ep_ready && send) begin
               sent_report = fresh;
               beat.sent = 1'b1;
               beat.mods = fresh[7:0];
               beat.keys = fresh[REPORT_W-1:8];
            end
         end
         default: ;
      endcase
      return beat;
   endfunction

   task automatic report_mismatch(input string msg);
      // Printing is capped so a broken block cannot flood the log.
      if (error_count < 40)
         $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Sends one item, with a random number of idle cycles ahead of it. Valid is
   // left high after the beat is taken, so back-to-back beats never see valid
   // dropped and raised in the same time step; wait_quiet lowers it.
   task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                            input logic ep_ready);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= data;
      req_endpoint_ready <= ep_ready;
      do @(posedge clock); while (req_stall);
      pending_reports.push_back(predict_report(op, data, ep_ready));
   endtask

   task automatic send_frame(input logic [7:0] scancode, input logic [7:0] key_state);
      send_item(OP_BYTE, 8'h00, 1'b0);
      send_item(OP_BYTE, scancode, 1'b1);
      send_item(OP_BYTE, key_state, 1'b0);
   endtask

   // Holds the sender off until every predicted beat has been checked.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   // Every item answers with one beat, so once the queue is empty the block
   // is idle and the register may be written.
   task automatic write_idle_period(input logic [9:0] period);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_idle_period_ms <= period;
      do @(posedge clock); while (!csr_ready);
      idle_period = period;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Scancodes lean on the low codes, so that more keys are held than there
   // are slots, and on the modifier keys.
   function automatic logic [7:0] pick_scancode();
      int r;
      r = $urandom_range(99);
      if (r < 40)
         return 8'($urandom_range(15));
      else if (r < 60)
         return 8'($urandom_range(MOD_FIRST + 7, MOD_FIRST));
      else
         return 8'($urandom_range(255));
   endfunction

   // Directed pass over the frame parser and the report builder, starting
   // from reset with the default idle period of 500.
   task automatic test_frame_parsing();
      // The timer starts expired, so the very first poll sends an empty report.
      send_item(OP_POLL, 8'hFF, 1'b1);
      // A non-zero byte where a header belongs is skipped.
      send_item(OP_BYTE, 8'h5A, 1'b1);
      // Key code zero still fills a slot with the code 0.
      send_frame(8'h00, PRESS_MARK);
      send_frame(8'hE7, PRESS_MARK);
      // A key at the top of the table is neither a modifier nor a slot.
      send_frame(8'hFF, PRESS_MARK);
      send_frame(8'h7F, PRESS_MARK);
      // The report has changed, but the endpoint is busy.
      send_item(OP_POLL, 8'h00, 1'b0);
      send_item(OP_POLL, 8'h00, 1'b1);
      // Nothing changed and the timer is running: nothing goes out.
      send_item(OP_POLL, 8'h00, 1'b1);
      send_item(OP_TICK, 8'hFF, 1'b1);
      send_item(OP_UNUSED, 8'hFF, 1'b1);
      // Any state byte other than the press mark releases the key.
      send_frame(8'h7F, 8'hAA);
      send_item(OP_POLL, 8'h00, 1'b1);
   endtask

   // The idle timer under the register's extremes: zero turns the resend
   // off, small periods expire after a few ticks, large ones hold it off.
   task automatic test_idle_period();
      logic [9:0] periods[5];
      periods = '{10'd0, 10'd1, 10'd1020, 10'd3, 10'd1023};
      foreach (periods[p]) begin
         write_idle_period(periods[p]);
         send_item(OP_POLL, 8'h00, 1'b1);
         repeat (2) send_item(OP_TICK, 8'h00, 1'b0);
         send_item(OP_POLL, 8'h00, 1'b0);
         repeat (2) send_item(OP_TICK, 8'h00, 1'b0);
         send_item(OP_POLL, 8'h00, 1'b1);
         send_frame(pick_scancode(), PRESS_MARK);
         send_item(OP_POLL, 8'h00, 1'b1);
      end
   endtask

   // Random traffic in phases, each under its own idle period. Most of it is
   // well-formed frames with random content, mixed with ticks, polls and
   // stray bytes that knock the parser off its frame.
   task automatic test_random_traffic();
      logic [9:0] periods[6];
      int         counted;
      int         r;
      periods = '{10'($urandom_range(1023)), 10'd0, 10'd2, 10'd1023,
                  10'($urandom_range(30, 1)), 10'd1};
      foreach (periods[p]) begin
         write_idle_period(periods[p]);
         // One phase runs flat out on both channels.
         idle_pct  = (p == 2) ? 0 : 29;
         stall_pct = (p == 2) ? 0 : 29;
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            // Midway through one phase the sender waits for the block to drain.
            if (p == 1 && counted == ITEMS_PER_PHASE / 2)
               wait_quiet();
            r = $urandom_range(99);
            if (r < 55) begin
               send_frame(pick_scancode(),
                          ($urandom_range(99) < 55) ? PRESS_MARK : 8'($urandom_range(255)));
               counted += 3;
            end else if (r < 70) begin
               send_item(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
               counted++;
            end else if (r < 88) begin
               send_item(OP_POLL, 8'($urandom_range(255)), ($urandom_range(3) != 0));
               counted++;
            end else if (r < 95) begin
               send_item(OP_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
               counted++;
            end else begin
               // The unused op is ignored, so it does not count as traffic.
               send_item(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
         end
      end
      idle_pct  = 29;
      stall_pct = 29;
   endtask

   // Checks each result beat taken from the block against the oldest
   // prediction, then picks the receiver's stall for the next cycle.
   always @(posedge clock) begin : result_check
      kbd_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("result beat arrived with no item waiting for it");
         end else begin
            want = pending_reports.pop_front();
            check_field("report_sent", 8'(rsp_report_sent), 8'(want.sent));
            check_field("modifiers", rsp_modifiers, want.mods);
            check_field("key_0", 8'(rsp_key_0), 8'(want.keys[0]));
            check_field("key_1", 8'(rsp_key_1), 8'(want.keys[1]));
            check_field("key_2", 8'(rsp_key_2), 8'(want.keys[2]));
            check_field("key_3", 8'(rsp_key_3), 8'(want.keys[3]));
            check_field("key_4", 8'(rsp_key_4), 8'(want.keys[4]));
            check_field("key_5", 8'(rsp_key_5), 8'(want.keys[5]));
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Ends a hung run: no beat on any channel for too long.
   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ERROR at %0t ns: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_frame_parsing();
      test_idle_period();
      test_random_traffic();
      wait_quiet();
      // Give a stray late beat time to show up before the verdict.
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
